/* rtl/core/sha256_pkg.sv */
// SHA-256 stream hasher package: round constants, initial hash values,
// controller state type and the command struct. No dependencies.
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenOffset  = 56;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam int unsigned DigestWords = 8;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       wr_byte;    // write byte into block buffer
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       load;       // copy chain into working vars, start schedule
        logic       round;      // run one round
        logic       add;        // fold working vars into chain
        logic       restart;    // reload initial hash values
        logic       shift_out;  // rotate chain words for output
    } t_cmd;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h [8] = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

endpackage

/* rtl/core/sha256_if.sv */
// Valid/ready stream interfaces for the hasher input and digest output.
// No dependencies.
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/core/sha256_stream_hasher_top.sv */
// SHA-256 stream hasher top. A data byte goes into the block buffer;
// the 64th byte of a block starts the block load over the byte-wide
// buffer RAM port, the round loop and the fold into the chain words. A
// finish item pads, compresses one or two blocks and then emits eight
// digest words, one per cycle while out_if.ready is high. Synchronous
// active-low reset loads the initial hash values and clears count and length.
module sha256_stream_hasher_top (
    input logic          i_clk,
    input logic          i_rst_n,
    sha256_in_if.sink    in_if,
    sha256_out_if.source out_if
);
    import sha256_pkg::*;

    t_cmd        cmd;
    logic [5:0]  rd_addr, round;
    logic        busy, chain_reset;
    t_cmd        cmd_dp;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_kind       (in_if.kind),
        .i_data_byte  (in_if.data_byte),
        .o_in_ready   (in_if.ready),
        .i_out_ready  (out_if.ready),
        .o_out_valid  (out_if.valid),
        .o_word_index (out_if.word_index),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr),
        .o_round      (round),
        .o_busy       (busy)
    );

    // reset also reloads the chain words
    assign chain_reset = !i_rst_n;
    always_comb begin
        cmd_dp = cmd;
        cmd_dp.restart = cmd.restart || chain_reset;
    end

    sha256_datapath u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd_dp),
        .i_rd_addr (rd_addr),
        .i_round   (round),
        .o_chain0  (out_if.digest_word)
    );

    assign out_if.last_word = (out_if.word_index == 3'd7);

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_if.ready |-> !busy && !out_if.valid) else $error("ready while busy");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid && out_if.ready && out_if.last_word |=> in_if.ready)
        else $error("no return to idle after digest");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_if.ready && out_if.valid)) else $error("input and output overlap");
endmodule

/* rtl/core/sha256_ram.sv */
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module sha256_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/sha256_datapath.sv */
// SHA-256 datapath: block buffer RAM, schedule, working vars, chain words.
// Depends on sha256_pkg and sha256_ram.
module sha256_datapath (
    input  logic                i_clk,
    input  sha256_pkg::t_cmd    i_cmd,
    input  logic [5:0]          i_rd_addr,
    input  logic [5:0]          i_round,
    output logic [31:0]         o_chain0
);
    import sha256_pkg::*;

    logic [7:0] rd_byte;
    t_word      r_w [16];
    t_word      r_v [8];
    t_word      r_h [8];
    t_word      w_cur, w_new, s0, s1, t1, t2;

    sha256_ram #(.WIDTH(8), .DEPTH(BlockBytes)) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_byte),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_cmd.wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_byte)
    );

    // message expansion on the rolling 16-word window
    always_comb begin
        s0    = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]}
                ^ (r_w[1] >> 3);
        s1    = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
                ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = (i_round < 6'd16) ? r_w[0] : w_new;
        t1 = r_v[7] + ({r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
             ^ {r_v[4][24:0], r_v[4][31:25]}) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(i_round) + w_cur;
        t2 = ({r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
             ^ {r_v[0][21:0], r_v[0][31:22]})
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // shift bytes into the window while loading, roll it during rounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w[15] <= {r_w[15][23:0], rd_byte};
            if (i_rd_addr[1:0] == 2'd1 && i_round != 6'd0) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            end
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
            for (int i = 1; i < 8; i++) r_v[i] <= r_v[i-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
    end

    // chain words: restart, fold, rotate out
    always_ff @(posedge i_clk) begin
        if (i_cmd.restart) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else if (i_cmd.add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
            r_h[7] <= r_h[0];
        end
    end

    assign o_chain0 = r_h[0];
endmodule

/* rtl/core/sha256_ctrl.sv */
// SHA-256 controller: byte fill, padding, block load, 64 rounds, digest out.
// Depends on sha256_pkg.
module sha256_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_kind,
    input  logic [7:0]       i_data_byte,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_word_index,
    output sha256_pkg::t_cmd o_cmd,
    output logic [5:0]       o_rd_addr,
    output logic [5:0]       o_round,
    output logic             o_busy
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_total, n_total;
    logic [6:0]  r_cnt, n_cnt;      // load byte count / round count
    logic        r_final, n_final;  // padding holds the length block
    logic        r_second, n_second;// pad block needs a second block
    logic [2:0]  r_widx, n_widx;
    logic [63:0] bits;
    logic        acc;

    assign acc  = i_in_valid && o_in_ready;
    assign bits = {r_total, 3'b000};

    // next state
    always_comb begin
        n_state = r_state; n_fill = r_fill; n_total = r_total; n_cnt = r_cnt;
        n_final = r_final; n_second = r_second; n_widx = r_widx;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && !i_kind) begin
                    n_fill  = r_fill + 6'd1;
                    n_total = r_total + 61'd1;
                    if (r_fill == 6'd63) begin
                        n_state = ST_LOAD; n_cnt = '0; n_final = 1'b0;
                    end
                end else if (acc) begin
                    n_fill   = r_fill + 6'd1;
                    n_second = (r_fill >= 6'(LenOffset));
                    n_final  = 1'b0;
                    // pad byte in the last slot fills the block: compress at once
                    if (r_fill == 6'd63) begin
                        n_state = ST_LOAD; n_cnt = '0;
                    end else begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    n_state = ST_LOAD; n_cnt = '0;
                end
            end
            ST_LOAD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    n_state = ST_ROUND; n_cnt = '0;
                end
            end
            ST_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_final) begin
                    n_state = ST_EMIT; n_widx = '0;
                end else if (r_second) begin
                    n_second = 1'b0; n_final = 1'b1; n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        n_state = ST_IDLE; n_fill = '0; n_total = '0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // padding that started with room for the length is already final
        if (r_state == ST_IDLE && acc && i_kind && r_fill < 6'(LenOffset))
            n_final = 1'b1;
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready   = (r_state == ST_IDLE);
        o_out_valid  = (r_state == ST_EMIT);
        o_word_index = r_widx;
        o_rd_addr    = r_cnt[5:0];
        o_round      = (r_state == ST_LOAD) ? r_cnt[5:0] : r_cnt[5:0];
        o_busy       = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr_byte = acc;
                o_cmd.wr_addr = r_fill;
                o_cmd.wr_data = i_kind ? PadByte : i_data_byte;
            end
            ST_PAD: begin
                o_cmd.wr_byte = 1'b1;
                o_cmd.wr_addr = r_fill;
                o_cmd.wr_data = (r_final && r_fill >= 6'(LenOffset))
                                ? bits[8*(63-r_fill) +: 8] : 8'h00;
            end
            ST_LOAD:  o_cmd.load = (r_cnt != 7'd0);
            ST_ROUND: o_cmd.round = 1'b1;
            ST_ADD:   o_cmd.add = 1'b1;
            ST_EMIT: begin
                o_cmd.shift_out = i_out_ready;
                o_cmd.restart   = i_out_ready && (r_widx == 3'd7);
            end
            default: ;
        endcase
        if (r_state == ST_LOAD) o_round = r_cnt[5:0] - 6'd1;
        if (r_state == ST_LOAD) o_rd_addr = r_cnt[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_fill <= '0; r_total <= '0; r_cnt <= '0;
            r_final <= 1'b0; r_second <= 1'b0; r_widx <= '0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_total <= n_total; r_cnt <= n_cnt;
            r_final <= n_final; r_second <= n_second; r_widx <= n_widx;
        end
    end
endmodule

/* tb/tb_sha256_if.sv */
// Testbench copy-free note: the valid/ready interfaces come from the RTL file
// sha256_if.sv; this file only holds shared testbench types. No dependencies.
`timescale 1ns / 100ps
package tb_sha256_types;
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
endpackage

/* tb/tb.sv */
// Self-checking testbench for sha256_stream_hasher_top: drives byte and finish
// requests, predicts the eight digest words per message, compares each output.
// Depends on sha256_pkg, sha256_if.sv and tb_sha256_types.
`timescale 1ns / 100ps
module tb;
    import sha256_pkg::*;
    import tb_sha256_types::*;

    localparam int CycleLimit = 2000000;

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  in_if ();
    sha256_out_if out_if ();

    sha256_stream_hasher_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_if  (in_if),
        .out_if (out_if)
    );

    // predictor state
    logic [31:0] hash_chain [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [60:0] msg_bytes;

    t_req    pending_reqs [$];
    t_digest expected_digests [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_sender;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    bit          stim_done;
    bit          in_accepted;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // compress the current message block into the chaining words
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + round_k(t[5:0]) + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_chain[i] = init_h(i[2:0]);
        block_fill = 0;
        msg_bytes = '0;
    endtask

    // advance the predictor by one accepted request
    task automatic predict_digest(input t_req r);
        logic [63:0] bit_len;
        t_digest d;
        if (r.kind == KIND_DATA) begin
            msg_block[block_fill] = r.data_byte;
            block_fill = (block_fill + 1) % 64;
            msg_bytes = msg_bytes + 61'd1;
            if (block_fill == 0) sha_compress();
            return;
        end
        bit_len = {msg_bytes, 3'b000};
        msg_block[block_fill] = PadByte;
        block_fill++;
        if (block_fill > LenOffset) begin
            while (block_fill < BlockBytes) msg_block[block_fill++] = 8'h00;
            sha_compress();
            block_fill = 0;
        end
        while (block_fill < LenOffset) msg_block[block_fill++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
        sha_compress();
        for (int i = 0; i < 8; i++) begin
            d.digest_word = hash_chain[i];
            d.word_index  = i[2:0];
            d.last_word   = (i == 7);
            expected_digests.push_back(d);
        end
        restart_message();
    endtask

    task automatic queue_message(input int unsigned len);
        t_req r;
        for (int unsigned i = 0; i < len; i++) begin
            r.kind = KIND_DATA;
            r.data_byte = 8'($urandom);
            pending_reqs.push_back(r);
        end
        r.kind = KIND_FINISH;
        r.data_byte = 8'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_digests.size() != 0) @(posedge i_clk);
    endtask

    // driver: change inputs at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_accepted) begin
            // the held request was taken at the last rising edge
            if (pending_reqs.size() != 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct) begin
                in_if.valid     <= 1'b1;
                in_if.kind      <= pending_reqs[0].kind;
                in_if.data_byte <= pending_reqs[0].data_byte;
                pending_reqs.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: sample at the rising edge
    always @(posedge i_clk) begin
        t_digest got, want;
        in_accepted <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_digest('{kind: in_if.kind, data_byte: in_if.data_byte});
            end
            if (out_if.valid && out_if.ready) begin
                got = '{digest_word: out_if.digest_word, word_index: out_if.word_index,
                        last_word: out_if.last_word};
                if (expected_digests.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected digest word %h idx %0d last %b",
                                 got.digest_word, got.word_index, got.last_word);
                end else begin
                    want = expected_digests.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     want.digest_word, want.word_index, want.last_word,
                                     got.digest_word, got.word_index, got.last_word);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_req r;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = KIND_DATA;
        in_if.data_byte = 8'h00;
        out_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sender = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        restart_message();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, finish with nonzero byte, byte extremes
        r.kind = KIND_FINISH; r.data_byte = 8'h00; pending_reqs.push_back(r);
        r.kind = KIND_FINISH; r.data_byte = 8'hff; pending_reqs.push_back(r);
        r.kind = KIND_DATA; r.data_byte = 8'h00; pending_reqs.push_back(r);
        r.kind = KIND_DATA; r.data_byte = 8'hff; pending_reqs.push_back(r);
        r.kind = KIND_DATA; r.data_byte = 8'h55; pending_reqs.push_back(r);
        r.kind = KIND_DATA; r.data_byte = 8'haa; pending_reqs.push_back(r);
        r.kind = KIND_FINISH; r.data_byte = 8'h00; pending_reqs.push_back(r);
        queue_message(3);
        queue_message(0);
        wait_drained();

        // hold off until every digest word is out, then go on
        hold_sender = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;

        // random messages across idle phases; lengths hit the padding edges
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (phase)
                0: begin queue_message(55); queue_message(1); end
                1: begin queue_message(56); end
                2: begin queue_message(63); end
                default: begin queue_message(64); end
            endcase
            queue_message($urandom_range(12));
            wait_drained();
        end
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
